FILE: src/osfd_pkg.sv
// Package for the OFDM SIGNAL field decoder: field widths, status codes,
// rate code decoding, per-encoding divisors and their reciprocals.
// No dependencies.
`default_nettype none

package osfd_pkg;

    localparam int SIG_W   = 18;
    localparam int LEN_W   = 12;
    localparam int ENC_W   = 3;
    localparam int MOD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int NSYM_W  = 11;
    localparam int NUM_W   = 16;  // 22 + 8*len + d - 1 stays below 2^16
    localparam int RECIP_W = 20;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 24;
    localparam int NUM_ENC = 8;

    // Service + tail bits less one, added ahead of the rounding-up divide
    localparam logic [NUM_W-1:0] OVERHEAD_M1 = NUM_W'(21);

    typedef logic [STAT_W-1:0] t_status;
    typedef logic [ENC_W-1:0]  t_enc;
    typedef logic [MOD_W-1:0]  t_mod;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_PARITY = 2'd1;
    localparam t_status ST_RATE   = 2'd2;

    // Rate codes as they appear on bits 0..3
    localparam logic [3:0] RC_6M  = 4'd11;
    localparam logic [3:0] RC_9M  = 4'd15;
    localparam logic [3:0] RC_12M = 4'd10;
    localparam logic [3:0] RC_18M = 4'd14;
    localparam logic [3:0] RC_24M = 4'd9;
    localparam logic [3:0] RC_36M = 4'd13;
    localparam logic [3:0] RC_48M = 4'd8;
    localparam logic [3:0] RC_54M = 4'd12;

    // Data bits per OFDM symbol, by encoding index
    localparam logic [7:0] BITS_PER_SYM [NUM_ENC] = '{
        8'd24, 8'd36, 8'd48, 8'd72, 8'd96, 8'd144, 8'd192, 8'd216
    };

    // ceil(2^24 / d): exact floor divide for any 16-bit numerator
    localparam logic [RECIP_W-1:0] RECIP [NUM_ENC] = '{
        20'd699051, 20'd466034, 20'd349526, 20'd233017,
        20'd174763, 20'd116509, 20'd87382,  20'd77673
    };

    // Decoded header handed from the check stage to the divide pipeline
    typedef struct packed {
        t_status                 status;
        t_enc                    enc;
        t_mod                    modu;
        logic [LEN_W-1:0]        len;
        logic [NUM_W-1:0]        num;
        logic [RECIP_W-1:0]      recip;
    } t_hdr;

    // Rate code to {known, encoding index}
    function automatic logic [ENC_W:0] rate_decode(input logic [3:0] rc);
        logic [ENC_W:0] res;
        unique case (rc)
            RC_6M:   res = {1'b1, 3'd0};
            RC_9M:   res = {1'b1, 3'd1};
            RC_12M:  res = {1'b1, 3'd2};
            RC_18M:  res = {1'b1, 3'd3};
            RC_24M:  res = {1'b1, 3'd4};
            RC_36M:  res = {1'b1, 3'd5};
            RC_48M:  res = {1'b1, 3'd6};
            RC_54M:  res = {1'b1, 3'd7};
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/osfd_if.sv
// Valid/ready channel interfaces for the SIGNAL field decoder.
// Depends on osfd_pkg.
`default_nettype none

interface osfd_in_if;
    logic                        valid;
    logic                        ready;
    logic [osfd_pkg::SIG_W-1:0]  signal_bits;

    modport source (output valid, output signal_bits, input ready);
    modport sink   (input valid, input signal_bits, output ready);
endinterface

interface osfd_out_if;
    logic                         valid;
    logic                         ready;
    logic [osfd_pkg::STAT_W-1:0]  status;
    logic [osfd_pkg::ENC_W-1:0]   encoding;
    logic [osfd_pkg::MOD_W-1:0]   modulation;
    logic [osfd_pkg::LEN_W-1:0]   length_bytes;
    logic [osfd_pkg::NSYM_W-1:0]  symbol_count;

    modport source (output valid, output status, output encoding, output modulation,
                    output length_bytes, output symbol_count, input ready);
    modport sink   (input valid, input status, input encoding, input modulation,
                    input length_bytes, input symbol_count, output ready);
endinterface

`default_nettype wire

FILE: src/ofdm_signal_field_decode.sv
// Top level of the OFDM SIGNAL field decoder: three-stage pipeline
// (header check, reciprocal multiply, output register).
// Depends on osfd_pkg, osfd_if and osfd_hdr_check.
//
// Usage:
//   i_sig takes one 18-bit SIGNAL field per request (valid/ready).
//   o_res gives one result per request: status, encoding, modulation,
//   length_bytes and symbol_count. A parity or rate error zeroes the
//   encoding, modulation and symbol count; length_bytes always passes.
//   An accepted request loads stage 1, then moves through stage 2 to
//   the third register stage, which drives o_res.valid.
//   Throughput is one request per cycle while o_res.ready does not stall
//   the pipeline; the symbol count comes from a 16x20 multiply by a fixed
//   reciprocal of the bits per symbol, which has its own stage.
//   Each stage holds its data while the stage after it is full and
//   stalled; i_sig.ready falls only when all three stages are full and
//   o_res.ready is low, so bubbles are squeezed out during a stall.
//   Reset (synchronous, active low) empties the pipeline; no result
//   is lost or repeated across a stall.
`default_nettype none

module ofdm_signal_field_decode (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    osfd_in_if.sink    i_sig,
    osfd_out_if.source o_res
);
    import osfd_pkg::*;

    // Stage valid bits
    logic r_v1;
    logic r_v2;

    // Stage enables: a stage loads when it is empty or moving on
    logic en1, en2, en3;
    assign en3 = !o_res.valid || o_res.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_sig.ready = en1;

    // Stage 1: header check
    t_hdr n_hdr;
    t_hdr r_hdr1;

    osfd_hdr_check u_check (
        .i_bits (i_sig.signal_bits),
        .o_hdr  (n_hdr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_sig.valid;
        end
        if (en1 && i_sig.valid) begin
            r_hdr1 <= n_hdr;
        end
    end

    // Stage 2: numerator times reciprocal
    logic [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0] r_prod;
    t_status           r_st2;
    t_enc              r_enc2;
    t_mod              r_mod2;
    logic [LEN_W-1:0]  r_len2;

    assign n_prod = PROD_W'(r_hdr1.num) * PROD_W'(r_hdr1.recip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
        if (en2 && r_v1) begin
            r_prod <= n_prod;
            r_st2  <= r_hdr1.status;
            r_enc2 <= r_hdr1.enc;
            r_mod2 <= r_hdr1.modu;
            r_len2 <= r_hdr1.len;
        end
    end

    // Stage 3: output register, quotient is the product shifted down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res.valid <= 1'b0;
        end else if (en3) begin
            o_res.valid <= r_v2;
        end
        if (en3 && r_v2) begin
            o_res.status       <= r_st2;
            o_res.encoding     <= r_enc2;
            o_res.modulation   <= r_mod2;
            o_res.length_bytes <= r_len2;
            o_res.symbol_count <= r_prod[RECIP_SHIFT +: NSYM_W];
        end
    end

    // Checks
    a_no_rsvd_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.status == ST_OK || o_res.status == ST_PARITY
                         || o_res.status == ST_RATE))
        else $error("reserved status produced");

    a_err_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status != ST_OK
        |-> o_res.encoding == '0 && o_res.modulation == '0 && o_res.symbol_count == '0)
        else $error("error result carries nonzero fields");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status == ST_OK |-> o_res.symbol_count != '0)
        else $error("good header with zero symbols");

    a_mod_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.modulation == o_res.encoding[ENC_W-1:1])
        else $error("modulation does not follow encoding");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !en2 |=> r_v1 && $stable(r_hdr1))
        else $error("stage 1 lost data during stall");

endmodule

`default_nettype wire

FILE: src/osfd_hdr_check.sv
// SIGNAL header check: parity, rate code lookup, length extraction and
// the divide numerator / reciprocal selection. Combinational.
// Depends on osfd_pkg.
`default_nettype none

module osfd_hdr_check (
    input  wire logic [osfd_pkg::SIG_W-1:0] i_bits,
    output osfd_pkg::t_hdr                  o_hdr
);
    import osfd_pkg::*;

    logic           parity_bad;
    logic [ENC_W:0] rate_res;
    t_enc           enc;

    assign parity_bad = (^i_bits[16:0]) != i_bits[17];
    assign rate_res   = rate_decode(i_bits[3:0]);
    assign enc        = rate_res[ENC_W-1:0];

    always_comb begin
        o_hdr.len = i_bits[16:5];
        // 22 + 8*len + d - 1 gives the rounded-up quotient
        o_hdr.num = NUM_W'({o_hdr.len, 3'b000}) + OVERHEAD_M1
                    + NUM_W'(BITS_PER_SYM[enc]);
        if (parity_bad) begin
            o_hdr.status = ST_PARITY;
            o_hdr.enc    = '0;
            o_hdr.modu   = '0;
            o_hdr.recip  = '0;
        end else if (!rate_res[ENC_W]) begin
            o_hdr.status = ST_RATE;
            o_hdr.enc    = '0;
            o_hdr.modu   = '0;
            o_hdr.recip  = '0;
        end else begin
            o_hdr.status = ST_OK;
            o_hdr.enc    = enc;
            o_hdr.modu   = enc[ENC_W-1:1];  // two encodings per modulation
            o_hdr.recip  = RECIP[enc];
        end
    end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for ofdm_signal_field_decode: a directed table, then random
// SIGNAL fields checked against a local decoder model, with random stalls on both sides.
// Depends on osfd_pkg, osfd_if and the decoder RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import osfd_pkg::*;

    localparam int NUM_RANDOM  = 950;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    localparam t_mod MOD_BPSK  = 2'd0;
    localparam t_mod MOD_QPSK  = 2'd1;
    localparam t_mod MOD_QAM16 = 2'd2;
    localparam t_mod MOD_QAM64 = 2'd3;

    // One decoded SIGNAL header as it leaves the block
    typedef struct packed {
        t_status           status;
        t_enc              enc;
        t_mod              modu;
        logic [LEN_W-1:0]  len;
        logic [NSYM_W-1:0] nsym;
    } t_sig_result;

    // Directed row: field contents, plus a hand-typed result where it is obvious
    typedef struct packed {
        logic [3:0]       rate;
        logic             rsvd;
        logic [LEN_W-1:0] len;
        logic             bad_par;
        logic             typed;
        t_sig_result      want;
    } t_stim_row;

    localparam int NUM_DIRECTED = 22;

    t_stim_row dir_rows [NUM_DIRECTED] = '{
        // shortest and longest frames at the slowest and fastest rates
        '{RC_6M,  1'b0, 12'd0,    1'b0, 1'b1, '{ST_OK, 3'd0, MOD_BPSK, 12'd0, 11'd1}},
        '{RC_6M,  1'b0, 12'd4095, 1'b0, 1'b1, '{ST_OK, 3'd0, MOD_BPSK, 12'd4095, 11'd1366}},
        '{RC_54M, 1'b0, 12'd0,    1'b0, 1'b1, '{ST_OK, 3'd7, MOD_QAM64, 12'd0, 11'd1}},
        '{RC_54M, 1'b0, 12'd4095, 1'b0, 1'b1, '{ST_OK, 3'd7, MOD_QAM64, 12'd4095, 11'd152}},
        // all eighteen bits set: parity holds, 9 Mb/s
        '{RC_9M,  1'b1, 12'd4095, 1'b0, 1'b1, '{ST_OK, 3'd1, MOD_BPSK, 12'd4095, 11'd911}},
        // remaining rates
        '{RC_12M, 1'b0, 12'd1,    1'b0, 1'b0, '0},
        '{RC_18M, 1'b1, 12'd2048, 1'b0, 1'b0, '0},
        '{RC_24M, 1'b0, 12'd1500, 1'b0, 1'b0, '0},
        '{RC_36M, 1'b1, 12'd1000, 1'b0, 1'b0, '0},
        '{RC_48M, 1'b0, 12'd4095, 1'b0, 1'b0, '0},
        '{RC_48M, 1'b1, 12'd3,    1'b0, 1'b0, '0},
        '{RC_36M, 1'b0, 12'd2730, 1'b0, 1'b0, '0},
        // unknown rate codes, all zero field among them
        '{4'd0,   1'b0, 12'd0,    1'b0, 1'b1, '{ST_RATE, 3'd0, MOD_BPSK, 12'd0, 11'd0}},
        '{4'd7,   1'b0, 12'd4095, 1'b0, 1'b1, '{ST_RATE, 3'd0, MOD_BPSK, 12'd4095, 11'd0}},
        '{4'd5,   1'b1, 12'd1234, 1'b0, 1'b1, '{ST_RATE, 3'd0, MOD_BPSK, 12'd1234, 11'd0}},
        '{4'd1,   1'b0, 12'd2730, 1'b0, 1'b1, '{ST_RATE, 3'd0, MOD_BPSK, 12'd2730, 11'd0}},
        // parity errors, one with a bad rate code as well, then one good and one unknown rate
        '{RC_6M,  1'b0, 12'd50,   1'b1, 1'b1, '{ST_PARITY, 3'd0, MOD_BPSK, 12'd50, 11'd0}},
        '{4'd3,   1'b0, 12'd7,    1'b1, 1'b1, '{ST_PARITY, 3'd0, MOD_BPSK, 12'd7, 11'd0}},
        '{RC_9M,  1'b1, 12'd4095, 1'b1, 1'b1, '{ST_PARITY, 3'd0, MOD_BPSK, 12'd4095, 11'd0}},
        '{RC_54M, 1'b0, 12'd0,    1'b1, 1'b1, '{ST_PARITY, 3'd0, MOD_BPSK, 12'd0, 11'd0}},
        '{RC_24M, 1'b1, 12'd2047, 1'b0, 1'b0, '0},
        '{4'd6,   1'b1, 12'd0,    1'b0, 1'b1, '{ST_RATE, 3'd0, MOD_BPSK, 12'd0, 11'd0}}
    };

    logic i_clk;
    logic i_rst_n;

    osfd_in_if  sig_if ();
    osfd_out_if res_if ();

    ofdm_signal_field_decode dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sig   (sig_if),
        .o_res   (res_if)
    );

    t_sig_result decoded_q [$];
    t_sig_result next_decode;
    int          fail_cnt    = 0;
    int          stall_left  = 0;
    bit          tx_idle_en  = 1'b0;
    bit          rx_idle_en  = 1'b0;

    // Clock, 10 ns period
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Decode one SIGNAL field the way the block should
    function automatic t_sig_result decode_signal(input logic [SIG_W-1:0] bits);
        t_sig_result r;
        int          dbits;
        r      = '0;
        dbits  = 1;
        r.len  = bits[16:5];
        if ((^bits[16:0]) != bits[17]) begin
            r.status = ST_PARITY;
        end else begin
            r.status = ST_OK;
            case (bits[3:0])
                RC_6M:  begin r.enc = 3'd0; r.modu = MOD_BPSK;  dbits = 24;  end
                RC_9M:  begin r.enc = 3'd1; r.modu = MOD_BPSK;  dbits = 36;  end
                RC_12M: begin r.enc = 3'd2; r.modu = MOD_QPSK;  dbits = 48;  end
                RC_18M: begin r.enc = 3'd3; r.modu = MOD_QPSK;  dbits = 72;  end
                RC_24M: begin r.enc = 3'd4; r.modu = MOD_QAM16; dbits = 96;  end
                RC_36M: begin r.enc = 3'd5; r.modu = MOD_QAM16; dbits = 144; end
                RC_48M: begin r.enc = 3'd6; r.modu = MOD_QAM64; dbits = 192; end
                RC_54M: begin r.enc = 3'd7; r.modu = MOD_QAM64; dbits = 216; end
                default: r.status = ST_RATE;
            endcase
            // service + tail = 22 bits, rounded up to whole symbols
            if (r.status == ST_OK)
                r.nsym = NSYM_W'((22 + 8 * int'(r.len) + dbits - 1) / dbits);
        end
        return r;
    endfunction

    function automatic logic [SIG_W-1:0] build_field(input logic [3:0] rate, input logic rsvd,
                                                     input logic [LEN_W-1:0] len,
                                                     input logic bad_par);
        logic [SIG_W-1:0] bits;
        bits       = '0;
        bits[3:0]  = rate;
        bits[4]    = rsvd;
        bits[16:5] = len;
        bits[17]   = (^bits[16:0]) ^ bad_par;
        return bits;
    endfunction

    // Present one request, with an optional idle burst ahead of it
    task automatic send_field(input logic [SIG_W-1:0] bits, input t_sig_result want);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            sig_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sig_if.valid       <= 1'b1;
        sig_if.signal_bits <= bits;
        next_decode        <= want;
        @(posedge i_clk);
        while (!sig_if.ready) @(posedge i_clk);
    endtask

    // Hold off the sender until every queued header has come back
    task automatic wait_empty();
        sig_if.valid <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
            fail_cnt++;
        end
    endtask

    // Result side: random stall bursts on res_if.ready
    always @(posedge i_clk) begin
        if (!rx_idle_en) begin
            res_if.ready <= 1'b1;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 4);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Queue a header per accepted request, compare each accepted result
    always @(posedge i_clk) begin
        t_sig_result want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: result with nothing expected, status %0d length %0d",
                             $realtime, res_if.status, res_if.length_bytes);
                    fail_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("status", want.status, res_if.status);
                    check_field("encoding", want.enc, res_if.encoding);
                    check_field("modulation", want.modu, res_if.modulation);
                    check_field("length_bytes", want.len, res_if.length_bytes);
                    check_field("symbol_count", want.nsym, res_if.symbol_count);
                end
            end
            if (sig_if.valid && sig_if.ready)
                decoded_q.push_back(next_decode);
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus
    initial begin
        logic [SIG_W-1:0] bits;
        logic [3:0]       rate;
        logic [LEN_W-1:0] len;
        int               kind;
        int               len_sel;

        i_rst_n            = 1'b0;
        sig_if.valid       = 1'b0;
        sig_if.signal_bits = '0;
        res_if.ready       = 1'b0;
        next_decode        = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        foreach (dir_rows[i]) begin
            bits = build_field(dir_rows[i].rate, dir_rows[i].rsvd, dir_rows[i].len,
                               dir_rows[i].bad_par);
            send_field(bits, dir_rows[i].typed ? dir_rows[i].want : decode_signal(bits));
        end

        // Random fields, mostly well formed; idling is redrawn per stretch of 50, off for the last 150
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 50 == 0) begin
                tx_idle_en = (n < NUM_RANDOM - 150) && ($urandom_range(0, 3) != 0);
                rx_idle_en = (n < NUM_RANDOM - 150) && ($urandom_range(0, 3) != 0);
            end
            if (n == NUM_RANDOM / 2)
                wait_empty();

            len_sel = $urandom_range(0, 9);
            case (len_sel)
                0:       len = '0;
                1:       len = '1;
                2:       len = LEN_W'($urandom_range(0, 15));
                default: len = LEN_W'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 7))
                0:       rate = RC_6M;
                1:       rate = RC_9M;
                2:       rate = RC_12M;
                3:       rate = RC_18M;
                4:       rate = RC_24M;
                5:       rate = RC_36M;
                6:       rate = RC_48M;
                default: rate = RC_54M;
            endcase
            kind = $urandom_range(0, 19);
            if (kind < 14)
                bits = build_field(rate, 1'($urandom_range(0, 1)), len, 1'b0);
            else if (kind < 16)
                bits = build_field(4'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), len, 1'b0);
            else if (kind < 18)
                bits = build_field(rate, 1'($urandom_range(0, 1)), len, 1'b1);
            else
                bits = SIG_W'($urandom_range(0, (1 << SIG_W) - 1));
            send_field(bits, decode_signal(bits));
        end
        sig_if.valid <= 1'b0;

        // Drain, then allow for the pipeline depth
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
src/osfd_pkg.sv
src/osfd_if.sv
src/osfd_hdr_check.sv
src/ofdm_signal_field_decode.sv
dv/tb.sv
